FILE: rtl/led_pkg.sv
// shared types and constants for the edit distance engine
// no dependencies
package led_pkg;

  localparam int SYM_W   = 21;
  localparam int KIND_W  = 2;
  localparam int DIST_W  = 7;
  localparam int DistMax = 127;

  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

  typedef struct packed {
    logic valid;
    logic last;
  } link_ctl_t;

endpackage

FILE: rtl/led_cell.sv
// one cell of the systolic row: holds one first-string symbol and one cost column
// depends on led_pkg
module led_cell import led_pkg::*; #(
  parameter int CW  = 7,
  parameter int ROW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             init,
  input  logic             wr_en,
  input  logic [SYM_W-1:0] wr_sym,
  input  link_ctl_t        in_ctl,
  input  logic [SYM_W-1:0] in_sym,
  input  logic [CW-1:0]    in_up,
  input  logic [CW-1:0]    in_diag,
  output link_ctl_t        out_ctl,
  output logic [SYM_W-1:0] out_sym,
  output logic [CW-1:0]    out_up,
  output logic [CW-1:0]    out_diag
);

  logic [SYM_W-1:0] sym;
  logic [CW-1:0]    left;
  logic [CW:0]      up_cost;
  logic [CW:0]      left_cost;
  logic [CW:0]      sub_cost;
  logic [CW:0]      min_a;
  logic [CW:0]      cost;

  always_comb begin
    up_cost   = {1'b0, in_up} + 1'b1;
    left_cost = {1'b0, left} + 1'b1;
    sub_cost  = {1'b0, in_diag} + {{CW{1'b0}}, (sym != in_sym)};
    min_a     = (up_cost < left_cost) ? up_cost : left_cost;
    cost      = (min_a < sub_cost) ? min_a : sub_cost;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (init) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym <= wr_sym;
    end
    if (init) begin
      left <= CW'(ROW);
    end else if (in_ctl.valid) begin
      out_sym  <= in_sym;
      out_up   <= cost[CW-1:0];
      out_diag <= left;
      left     <= cost[CW-1:0];
    end
  end

endmodule

FILE: rtl/levenshtein_edit_distance.sv
// levenshtein edit distance engine, top level
// append transactions are accepted while idle; a compute result is loaded after the
// second string has streamed through the row of cells one symbol per cycle (directly
// when either string is empty), later if the output register is still held; input is
// taken again the cycle after the result is loaded; rst clears lengths, overflow flag
// and control; depends on led_pkg and led_cell
module levenshtein_edit_distance import led_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [20:0] symbol
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [6:0] distance
  output logic [0:0]  m_axis_tuser   // [0] overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = (LW > DIST_W) ? LW : DIST_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [LW-1:0]    first_length;
  logic [LW-1:0]    second_length;
  logic             truncated;
  logic [LW-1:0]    n1_run;
  logic [LW-1:0]    n2_run;
  logic [LW-1:0]    rd_idx;
  logic [LW-1:0]    res;
  logic             res_ovf;
  logic [DW-1:0]    res_ext;
  logic [DIST_W-1:0] dist_sat;
  logic             out_load;

  logic [SYM_W-1:0] second_text [MAX_LEN];
  logic [SYM_W-1:0] rd_data;

  logic             in_acc;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0] symbol;
  logic             app_first;
  logic             app_second;
  logic             start;
  logic             issue;

  logic             feed_valid;
  logic             feed_last;
  logic [LW-1:0]    feed_j;

  link_ctl_t        link_ctl  [MAX_LEN+1];
  logic [SYM_W-1:0] link_sym  [MAX_LEN+1];
  logic [LW-1:0]    link_up   [MAX_LEN+1];
  logic [LW-1:0]    link_diag [MAX_LEN+1];
  link_ctl_t        cap_ctl;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser;
  assign symbol        = s_axis_tdata[SYM_W-1:0];

  always_comb begin
    app_first  = 1'b0;
    app_second = 1'b0;
    start      = 1'b0;
    if (in_acc) begin
      unique case (kind)
        KIND_FIRST:  app_first  = 1'b1;
        KIND_SECOND: app_second = 1'b1;
        KIND_RUN:    start      = 1'b1;
        default:     ;
      endcase
    end
  end

  assign issue    = (state == S_RUN) && (rd_idx < n2_run);
  assign cap_ctl  = link_ctl[n1_run];
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // second string store
  always_ff @(posedge clk) begin
    if (app_second && (second_length < LW'(MAX_LEN))) begin
      second_text[second_length[IW-1:0]] <= symbol;
    end
    rd_data <= second_text[rd_idx[IW-1:0]];
  end

  // feed stage, aligned with the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_valid <= 1'b0;
    end else begin
      feed_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    feed_last <= (rd_idx == n2_run - 1'b1);
    feed_j    <= rd_idx + 1'b1;
  end

  assign link_ctl[0]  = '{valid: feed_valid, last: feed_last};
  assign link_sym[0]  = rd_data;
  assign link_up[0]   = feed_j;
  assign link_diag[0] = feed_j - 1'b1;

  for (genvar c = 0; c < MAX_LEN; c++) begin : g_cell
    led_cell #(
      .CW  (LW),
      .ROW (c + 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .init     (start),
      .wr_en    (app_first && (first_length < LW'(MAX_LEN)) &&
                 (first_length[IW-1:0] == IW'(c))),
      .wr_sym   (symbol),
      .in_ctl   (link_ctl[c]),
      .in_sym   (link_sym[c]),
      .in_up    (link_up[c]),
      .in_diag  (link_diag[c]),
      .out_ctl  (link_ctl[c+1]),
      .out_sym  (link_sym[c+1]),
      .out_up   (link_up[c+1]),
      .out_diag (link_diag[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      truncated     <= 1'b0;
      rd_idx        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (app_first) begin
        if (first_length < LW'(MAX_LEN)) begin
          first_length <= first_length + 1'b1;
        end else begin
          truncated <= 1'b1;
        end
      end
      if (app_second) begin
        if (second_length < LW'(MAX_LEN)) begin
          second_length <= second_length + 1'b1;
        end else begin
          truncated <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            first_length  <= '0;
            second_length <= '0;
            truncated     <= 1'b0;
            rd_idx        <= '0;
            state         <= ((first_length == '0) || (second_length == '0)) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (cap_ctl.valid && cap_ctl.last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n1_run  <= first_length;
      n2_run  <= second_length;
      res_ovf <= truncated;
      res     <= (first_length == '0) ? second_length : first_length;
    end else if ((state == S_RUN) && cap_ctl.valid && cap_ctl.last) begin
      res <= link_up[n1_run];
    end
  end

  assign res_ext  = DW'(res);
  assign dist_sat = (res_ext > DW'(DistMax)) ? DIST_W'(DistMax) : res_ext[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata    <= {1'b0, dist_sat};
      m_axis_tuser[0] <= res_ovf;
    end
  end

endmodule

FILE: test/levenshtein_edit_distance_test.sv
`timescale 1ns / 1ps
// testbench for the edit distance engine: streams symbol transactions, predicts the
// distance and overflow flag of every compute and checks each result in order
// depends on led_pkg and levenshtein_edit_distance
module levenshtein_edit_distance_test import led_pkg::*;;

  localparam int MAX_LEN = 64;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [SYM_W-1:0] SYM_TOP = '1;
  localparam logic [SYM_W-1:0] PAST_UNICODE = 21'h110000;

  typedef enum {SYM_NARROW, SYM_WIDE, SYM_EDITED} sym_mode_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } score_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [20:0] symbol
  logic [1:0]  s_axis_tuser = '0;  // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [6:0] distance
  logic [0:0]  m_axis_tuser;  // [0] overflow

  logic [SYM_W-1:0] first_sym [MAX_LEN];
  logic [SYM_W-1:0] second_sym [MAX_LEN];
  int     first_len = 0;
  int     second_len = 0;
  logic   dropped = 1'b0;
  score_t pending_scores [$];
  int     mismatches = 0;
  int     loaded_items = 0;
  bit     steady = 1'b0;

  levenshtein_edit_distance #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // single row dynamic programming over the loaded strings
  function automatic logic [DIST_W-1:0] edit_distance();
    int row [MAX_LEN+1];
    int diag, up, sub, best;
    for (int j = 0; j <= second_len; j++) row[j] = j;
    for (int i = 1; i <= first_len; i++) begin
      diag = row[0];
      row[0] = i;
      for (int j = 1; j <= second_len; j++) begin
        up = row[j];
        sub = diag + ((first_sym[i-1] == second_sym[j-1]) ? 0 : 1);
        best = up + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        if (sub < best) best = sub;
        row[j] = best;
        diag = up;
      end
    end
    if (row[second_len] > DistMax) return DIST_W'(DistMax);
    return DIST_W'(row[second_len]);
  endfunction

  task automatic track_input(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym);
    score_t score;
    case (kind)
      KIND_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_sym[first_len] = sym;
          first_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_sym[second_len] = sym;
          second_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_RUN: begin
        score.distance = edit_distance();
        score.overflow = dropped;
        pending_scores = {pending_scores, score};
        first_len = 0;
        second_len = 0;
        dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym);
    while (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, sym};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    track_input(kind, sym);
    if (kind != KIND_UNUSED) loaded_items++;
  endtask

  task automatic wait_for_scores();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol(input sym_mode_t mode);
    if (mode == SYM_NARROW) return SYM_W'($urandom_range(3));
    return SYM_W'($urandom);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 88) return $urandom_range(10);
    if (r < 97) return $urandom_range(40, 11);
    return $urandom_range(70, 60);
  endfunction

  // load both strings in random interleaving, with stray unused kinds, then compute
  task automatic send_pair(input int n1, input int n2, input sym_mode_t mode);
    logic [SYM_W-1:0] a [$];
    logic [SYM_W-1:0] b [$];
    int i, j;
    for (i = 0; i < n1; i++) a = {a, pick_symbol(mode)};
    for (j = 0; j < n2; j++) begin
      if (mode == SYM_EDITED && j < n1 && $urandom_range(9) < 7) b = {b, a[j]};
      else b = {b, pick_symbol(mode)};
    end
    i = 0;
    j = 0;
    while (i < n1 || j < n2) begin
      if ($urandom_range(19) == 0) send_item(KIND_UNUSED, SYM_W'($urandom));
      if (j >= n2 || (i < n1 && $urandom_range(1) == 1)) begin
        send_item(KIND_FIRST, a[i]);
        i++;
      end else begin
        send_item(KIND_SECOND, b[j]);
        j++;
      end
    end
    send_item(KIND_RUN, SYM_W'($urandom));
  endtask

  task automatic send_random_pair();
    send_pair(pick_length(), pick_length(), sym_mode_t'($urandom_range(2)));
  endtask

  task automatic test_empty_strings();
    send_item(KIND_RUN, SYM_TOP);
    send_item(KIND_FIRST, 21'd5);
    send_item(KIND_FIRST, 21'd6);
    send_item(KIND_FIRST, 21'd7);
    send_item(KIND_RUN, '0);
    send_item(KIND_SECOND, 21'd9);
    send_item(KIND_SECOND, 21'd9);
    send_item(KIND_RUN, '0);
  endtask

  task automatic test_symbol_extremes();
    send_item(KIND_FIRST, '0);
    send_item(KIND_FIRST, SYM_TOP);
    send_item(KIND_UNUSED, SYM_TOP);
    send_item(KIND_SECOND, SYM_TOP);
    send_item(KIND_SECOND, '0);
    send_item(KIND_RUN, '0);
    send_item(KIND_FIRST, PAST_UNICODE);
    send_item(KIND_SECOND, PAST_UNICODE);
    send_item(KIND_RUN, '0);
    send_item(KIND_FIRST, 21'd1);
    send_item(KIND_FIRST, 21'd2);
    send_item(KIND_FIRST, 21'd3);
    send_item(KIND_SECOND, 21'd1);
    send_item(KIND_SECOND, 21'd3);
    send_item(KIND_RUN, '0);
  endtask

  // strings past their limit, the widest distance, and the flag clearing afterwards
  task automatic test_full_strings();
    for (int i = 0; i <= MAX_LEN; i++) send_item(KIND_FIRST, SYM_W'(i));
    for (int i = 0; i < MAX_LEN; i++) send_item(KIND_SECOND, SYM_W'(i + 1000));
    send_item(KIND_RUN, '0);
    send_item(KIND_RUN, '0);
    for (int i = 0; i <= MAX_LEN; i++) send_item(KIND_SECOND, SYM_W'($urandom));
    send_item(KIND_RUN, '0);
  endtask

  task automatic test_drained_pairs();
    for (int k = 0; k < 6; k++) begin
      send_random_pair();
      wait_for_scores();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    for (int k = 0; k < 10; k++) send_random_pair();
    wait_for_scores();
    steady = 1'b0;
  endtask

  task automatic test_random_pairs();
    int first_mark;
    first_mark = loaded_items;
    while (loaded_items - first_mark < 300) begin
      if ($urandom_range(24) == 0) send_item(KIND_RUN, SYM_W'($urandom));
      send_random_pair();
    end
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= steady || $urandom_range(99) >= 35;
  end

  always @(posedge clk) begin : check_results
    score_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_scores.size() == 0) begin
        note_mismatch("result count", 0, 1);
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata[DIST_W-1:0] != want.distance)
          note_mismatch("distance", int'(want.distance), int'(m_axis_tdata[DIST_W-1:0]));
        if (m_axis_tuser[0] != want.overflow)
          note_mismatch("overflow", int'(want.overflow), int'(m_axis_tuser[0]));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_strings();
    test_symbol_extremes();
    test_full_strings();
    test_drained_pairs();
    test_steady_stream();
    test_random_pairs();
    wait_for_scores();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
